// ----- hdl/aee_pkg.sv -----
// Shared types and constants for the exception entry unit.
package aee_pkg;

   typedef enum logic [2:0] {
      KIND_RESET    = 3'd0,
      KIND_UNDEF    = 3'd1,
      KIND_SWI      = 3'd2,
      KIND_PABORT   = 3'd3,
      KIND_DABORT   = 3'd4,
      KIND_IRQ      = 3'd5,
      KIND_FIQ      = 3'd6,
      KIND_INVALID  = 3'd7
   } exc_kind_type;

   typedef enum logic [1:0] {
      STATUS_TAKEN   = 2'd0,
      STATUS_MASKED  = 2'd1,
      STATUS_INVALID = 2'd2
   } exc_status_type;

   typedef enum logic [2:0] {
      BANK_SVC = 3'd0,
      BANK_UND = 3'd1,
      BANK_ABT = 3'd2,
      BANK_IRQ = 3'd3,
      BANK_FIQ = 3'd4
   } exc_bank_type;

   // configuration register indexes
   localparam logic CSR_VECTOR_BASE  = 1'b0;
   localparam logic CSR_HIGH_VECTORS = 1'b1;

   localparam logic [31:0] HIGH_VECTOR_BASE = 32'hffff_0000;

   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_UND = 5'h1b;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_FIQ = 5'h11;

   localparam logic [4:0] VEC_RESET  = 5'h00;
   localparam logic [4:0] VEC_UNDEF  = 5'h04;
   localparam logic [4:0] VEC_SWI    = 5'h08;
   localparam logic [4:0] VEC_PABORT = 5'h0c;
   localparam logic [4:0] VEC_DABORT = 5'h10;
   localparam logic [4:0] VEC_IRQ    = 5'h18;
   localparam logic [4:0] VEC_FIQ    = 5'h1c;

   localparam int PSR_T_BIT = 5;
   localparam int PSR_F_BIT = 6;
   localparam int PSR_I_BIT = 7;

endpackage

// ----- hdl/arm_exception_entry_unit.sv -----
// Exception entry unit: maps an exception request onto the state changes for taking it.
//
// One request word is accepted per clock (busy stays low), and its result appears on the
// rsp_ ports with rsp_valid high for one cycle, after passing through the request register
// and then the result register, with the vector, status and link logic between them.
// Results cannot be held off. Program vector_base and high_vectors only while
// no request is in flight.
module arm_exception_entry_unit
   import aee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_cur_psr,
   input  logic [31:0] req_cur_pc,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_new_pc,
   output logic [31:0] rsp_new_psr,
   output logic [2:0]  rsp_bank,
   output logic [31:0] rsp_link_value,
   output logic [31:0] rsp_saved_psr,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0]   vector_base_ff;
   logic          high_vectors_ff;

   logic          req_valid_ff;
   exc_kind_type  req_kind_ff;
   logic [31:0]   req_psr_ff;
   logic [31:0]   req_pc_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff,  rsp_status_in;
   logic [31:0]   rsp_new_pc_ff,  rsp_new_pc_in;
   logic [31:0]   rsp_new_psr_ff, rsp_new_psr_in;
   logic [2:0]    rsp_bank_ff,    rsp_bank_in;
   logic [31:0]   rsp_link_ff,    rsp_link_in;
   logic [31:0]   rsp_saved_ff,   rsp_saved_in;

   logic          accept;
   logic [31:0]   base;
   logic [4:0]    vec_off;
   logic [4:0]    mode;
   exc_bank_type  bank;
   logic          link_plus4;
   logic          set_f;
   logic          masked;
   logic [31:0]   npsr;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_base_ff  <= '0;
         high_vectors_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VECTOR_BASE:  vector_base_ff  <= csr_wdata;
            CSR_HIGH_VECTORS: high_vectors_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_kind_ff <= exc_kind_type'(req_kind);
         req_psr_ff  <= req_cur_psr;
         req_pc_ff   <= req_cur_pc;
      end
   end

   // per-kind decode
   always_comb begin
      vec_off    = VEC_RESET;
      mode       = MODE_SVC;
      bank       = BANK_SVC;
      link_plus4 = 1'b0;
      set_f      = 1'b0;
      case (req_kind_ff)
         KIND_RESET: begin
            set_f = 1'b1;
         end
         KIND_UNDEF: begin
            vec_off = VEC_UNDEF;
            mode    = MODE_UND;
            bank    = BANK_UND;
         end
         KIND_SWI: begin
            vec_off = VEC_SWI;
         end
         KIND_PABORT: begin
            vec_off = VEC_PABORT;
            mode    = MODE_ABT;
            bank    = BANK_ABT;
         end
         KIND_DABORT: begin
            vec_off    = VEC_DABORT;
            mode       = MODE_ABT;
            bank       = BANK_ABT;
            link_plus4 = 1'b1;
         end
         KIND_IRQ: begin
            vec_off    = VEC_IRQ;
            mode       = MODE_IRQ;
            bank       = BANK_IRQ;
            link_plus4 = 1'b1;
         end
         KIND_FIQ: begin
            vec_off    = VEC_FIQ;
            mode       = MODE_FIQ;
            bank       = BANK_FIQ;
            link_plus4 = 1'b1;
            set_f      = 1'b1;
         end
         default: ;
      endcase
   end

   assign masked = (req_kind_ff == KIND_FIQ && req_psr_ff[PSR_F_BIT]) ||
                   (req_kind_ff == KIND_IRQ && req_psr_ff[PSR_I_BIT]);

   assign base = high_vectors_ff ? HIGH_VECTOR_BASE : {vector_base_ff[31:5], 5'b0};

   always_comb begin
      npsr            = {req_psr_ff[31:5], mode};
      npsr[PSR_F_BIT] = npsr[PSR_F_BIT] | set_f;
      npsr[PSR_T_BIT] = 1'b0;
      npsr[PSR_I_BIT] = 1'b1;
   end

   always_comb begin
      rsp_status_in  = STATUS_TAKEN;
      rsp_new_pc_in  = '0;
      rsp_new_psr_in = req_psr_ff;
      rsp_bank_in    = BANK_SVC;
      rsp_link_in    = '0;
      rsp_saved_in   = '0;
      if (req_kind_ff == KIND_INVALID) begin
         rsp_status_in = STATUS_INVALID;
      end else if (masked) begin
         rsp_status_in = STATUS_MASKED;
      end else begin
         // either base has its low five bits clear, so the offset just fills them
         rsp_new_pc_in  = base + {27'b0, vec_off};
         rsp_new_psr_in = npsr;
         rsp_bank_in    = bank;
         if (req_kind_ff != KIND_RESET) begin
            rsp_link_in  = req_pc_ff + (link_plus4 ? 32'd4 : 32'd0);
            rsp_saved_in = req_psr_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_new_pc_ff  <= rsp_new_pc_in;
         rsp_new_psr_ff <= rsp_new_psr_in;
         rsp_bank_ff    <= rsp_bank_in;
         rsp_link_ff    <= rsp_link_in;
         rsp_saved_ff   <= rsp_saved_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_pc     = rsp_new_pc_ff;
   assign rsp_new_psr    = rsp_new_psr_ff;
   assign rsp_bank       = rsp_bank_ff;
   assign rsp_link_value = rsp_link_ff;
   assign rsp_saved_psr  = rsp_saved_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted word did not produce a result two cycles later");

   a_not_taken_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_TAKEN) |->
         (rsp_new_pc == 32'd0 && rsp_link_value == 32'd0 &&
          rsp_saved_psr == 32'd0 && rsp_bank == BANK_SVC))
      else $error("dropped request carries nonzero entry fields");

   a_taken_psr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_TAKEN) |->
         (rsp_new_psr[PSR_I_BIT] && !rsp_new_psr[PSR_T_BIT]))
      else $error("taken exception psr lacks I set or T cleared");
`endif

endmodule
